FILE: rtl/bpdc_pkg.sv
package bpdc_pkg;

    localparam int CHANNELS         = 8;
    localparam int DEBOUNCE_SAMPLES = 13;
    localparam int TIMER_BITS       = 16;

    // fixed field widths
    localparam int CH_BITS      = 3;
    localparam int ELAPSED_BITS = 10;
    localparam int THRESH_BITS  = 16;
    localparam int CLASS_BITS   = 3;
    localparam int CFG_IDX_BITS = 2;

    localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_BITS    =
        ((TIMER_BITS > ELAPSED_BITS) ? TIMER_BITS : ELAPSED_BITS) + 1;
    localparam int GRADE_BITS  = (TIMER_BITS > THRESH_BITS) ? TIMER_BITS : THRESH_BITS;

    localparam logic [TIMER_BITS-1:0]  TIMER_MAX = '1;
    localparam logic [THRESH_BITS-1:0] SHORT_RESET  = THRESH_BITS'(500);
    localparam logic [THRESH_BITS-1:0] MEDIUM_RESET = THRESH_BITS'(2000);
    localparam logic [THRESH_BITS-1:0] LONG_RESET   = THRESH_BITS'(6000);

    typedef enum logic [CLASS_BITS-1:0] {
        CLS_RELEASED = 3'd0,
        CLS_PRESSED  = 3'd1,
        CLS_SHORT    = 3'd2,
        CLS_MEDIUM   = 3'd3,
        CLS_LONG     = 3'd4
    } t_press_class;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SHORT  = 2'd0,
        CFG_MEDIUM = 2'd1,
        CFG_LONG   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [THRESH_BITS-1:0] short_ms;
        logic [THRESH_BITS-1:0] medium_ms;
        logic [THRESH_BITS-1:0] long_ms;
    } t_thresholds;

    typedef struct packed {
        logic [DEBOUNCE_SAMPLES-1:0] hist;
        logic [TIMER_BITS-1:0]       timer;
    } t_chan_state;

endpackage

FILE: rtl/bpdc_in_if.sv
interface bpdc_in_if;
    import bpdc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CH_BITS-1:0]      channel;
    logic                    switch_down;
    logic [ELAPSED_BITS-1:0] elapsed_ms;

    modport source (output valid, output channel, output switch_down, output elapsed_ms,
                    input ready);
    modport sink   (input valid, input channel, input switch_down, input elapsed_ms,
                    output ready);
endinterface

FILE: rtl/bpdc_out_if.sv
interface bpdc_out_if;
    import bpdc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CH_BITS-1:0]    out_channel;
    logic [CLASS_BITS-1:0] press_class;

    modport source (output valid, output out_channel, output press_class, input ready);
    modport sink   (input valid, input out_channel, input press_class, output ready);
endinterface

FILE: rtl/button_press_duration_classifier.sv
// Flow: an item accepted at the input is registered in the input stage, and its result
// is then loaded into the output register once that register is free or being drained.
// Throughput: one item per cycle while the receiver keeps ready high; the per-channel state update is combinational.
// Reset (i_rst_n, synchronous, active low): thresholds return to 500/2000/6000 ms,
// every channel history reads all up, every hold timer is zero, both stages empty.
module button_press_duration_classifier
    import bpdc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [THRESH_BITS-1:0]  i_cfg_data,
    bpdc_in_if.sink                 i_in,
    bpdc_out_if.source              o_out
);

    // configuration
    t_thresholds r_thresh;

    // input stage
    logic                    r_s1_valid;
    logic [CH_BITS-1:0]      r_s1_channel;
    logic                    r_s1_down;
    logic [ELAPSED_BITS-1:0] r_s1_elapsed;

    // per-channel state, one entry per channel, read at the staged channel
    t_chan_state r_state [CHANNELS];

    // result stage
    logic                  r_out_valid;
    logic [CH_BITS-1:0]    r_out_channel;
    t_press_class          r_out_class;

    logic                   out_free;
    logic                   advance;
    logic                   in_range;
    logic [CH_IDX_BITS-1:0] ch_idx;
    t_chan_state            cur_state;
    t_chan_state            n_state;
    t_press_class           n_class;

    // the output register frees up when it is empty or being drained
    assign out_free = !r_out_valid || o_out.ready;
    assign advance  = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || advance;

    assign in_range  = 32'(r_s1_channel) < CHANNELS;
    assign ch_idx    = CH_IDX_BITS'(r_s1_channel);
    assign cur_state = r_state[ch_idx];

    bpdc_classify u_classify (
        .i_state   (cur_state),
        .i_down    (r_s1_down),
        .i_elapsed (r_s1_elapsed),
        .i_thresh  (r_thresh),
        .o_state   (n_state),
        .o_class   (n_class)
    );

    // threshold registers; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.short_ms  <= SHORT_RESET;
            r_thresh.medium_ms <= MEDIUM_RESET;
            r_thresh.long_ms   <= LONG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SHORT:  r_thresh.short_ms  <= i_cfg_data;
                CFG_MEDIUM: r_thresh.medium_ms <= i_cfg_data;
                CFG_LONG:   r_thresh.long_ms   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input stage control and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_channel <= i_in.channel;
            r_s1_down    <= i_in.switch_down;
            r_s1_elapsed <= i_in.elapsed_ms;
        end
    end

    // channel state is written as the item moves to the output, so a
    // following item on the same channel already sees the update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_state[i].hist  <= '1;
                r_state[i].timer <= '0;
            end
        end else if (advance && in_range) begin
            r_state[ch_idx] <= n_state;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_channel <= r_s1_channel;
            // a channel without state reads as released
            r_out_class   <= in_range ? n_class : CLS_RELEASED;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_channel = r_out_channel;
    assign o_out.press_class = r_out_class;

endmodule

FILE: rtl/bpdc_classify.sv
module bpdc_classify
    import bpdc_pkg::*;
(
    input  t_chan_state             i_state,
    input  logic                    i_down,
    input  logic [ELAPSED_BITS-1:0] i_elapsed,
    input  t_thresholds             i_thresh,
    output t_chan_state             o_state,
    output t_press_class            o_class
);

    logic [DEBOUNCE_SAMPLES-1:0] hist;
    logic [SUM_BITS-1:0]         sum;
    logic [TIMER_BITS-1:0]       timer;
    logic [GRADE_BITS-1:0]       t_ext;

    // newest sample in bit 0, 1 means up
    assign hist  = (i_state.hist << 1) | DEBOUNCE_SAMPLES'(!i_down);
    assign sum   = SUM_BITS'(i_state.timer) + SUM_BITS'(i_elapsed);
    assign timer = (sum > SUM_BITS'(TIMER_MAX)) ? TIMER_MAX : TIMER_BITS'(sum);
    assign t_ext = GRADE_BITS'(timer);

    always_comb begin
        o_state.hist = hist;
        if (hist == '0) begin
            o_state.timer = timer;
            priority if (t_ext > GRADE_BITS'(i_thresh.long_ms)) begin
                o_class = CLS_LONG;
            end else if (t_ext > GRADE_BITS'(i_thresh.medium_ms)) begin
                o_class = CLS_MEDIUM;
            end else if (t_ext > GRADE_BITS'(i_thresh.short_ms)) begin
                o_class = CLS_SHORT;
            end else begin
                o_class = CLS_PRESSED;
            end
        end else begin
            o_state.timer = '0;
            o_class       = CLS_RELEASED;
        end
    end

endmodule

FILE: tb/sv/button_press_duration_classifier_test.sv
`timescale 1ns / 1ps

module button_press_duration_classifier_test;
    import bpdc_pkg::*;

    // Register index past the end of the threshold list; writes to it are dropped.
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    localparam int MAX_IDLE     = 18;     // longest gap / stall drawn per item
    localparam int LONG_HOLD    = 300;    // receiver hold-off in the backpressure test
    localparam int CYCLE_LIMIT  = 500000; // watchdog, far above the slowest legal run
    localparam int PRINT_LIMIT  = 40;     // cap on printed mismatch lines

    // One expected classification, queued in acceptance order.
    typedef struct packed {
        logic [CH_BITS-1:0] channel;
        t_press_class       grade;
    } t_grade_item;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [THRESH_BITS-1:0] i_cfg_data;

    bpdc_in_if  samples_if();
    bpdc_out_if grades_if();

    button_press_duration_classifier i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (samples_if),
        .o_out      (grades_if)
    );

    // ------------------------------------------------------------------
    // Predictor state: per-channel debounce history and hold timer, plus
    // our own copy of the three grading thresholds.
    // ------------------------------------------------------------------
    logic [DEBOUNCE_SAMPLES-1:0] chan_hist [CHANNELS];
    logic [TIMER_BITS-1:0]       chan_hold [CHANNELS];
    logic [THRESH_BITS-1:0]      thr_short;
    logic [THRESH_BITS-1:0]      thr_medium;
    logic [THRESH_BITS-1:0]      thr_long;

    t_grade_item expected_grades[$];

    int  error_count  = 0;
    int  samples_sent = 0;
    int  cycle_count  = 0;
    int  sink_stall   = 0;   // cycles the receiver still holds ready low
    bit  sink_hold    = 1'b0; // long hold-off, owned by the backpressure test
    bit  src_idle_on  = 1'b1; // sender draws random gaps
    bit  sink_idle_on = 1'b1; // receiver draws random stalls
    bit  idle_toggle_en = 1'b1;

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d grades outstanding",
                     cycle_count, expected_grades.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Predictor. Shift the sample into the channel history (1 = up); only
    // a fully-down history counts as debounced down. While down, the hold
    // timer accumulates elapsed ms and saturates; the grade comes from strict
    // compares, long first. Any up bit in the history clears the timer.
    // ------------------------------------------------------------------
    function automatic t_press_class debounce_and_grade(input logic [CH_BITS-1:0] ch,
                                                        input logic down,
                                                        input logic [ELAPSED_BITS-1:0] el);
        logic [TIMER_BITS:0] sum;
        chan_hist[ch] = {chan_hist[ch][DEBOUNCE_SAMPLES-2:0], ~down};
        if (chan_hist[ch] != '0) begin
            chan_hold[ch] = '0;
            return CLS_RELEASED;
        end
        sum = chan_hold[ch] + el;
        chan_hold[ch] = (sum > TIMER_MAX) ? TIMER_MAX : sum[TIMER_BITS-1:0];
        if (chan_hold[ch] > thr_long)
            return CLS_LONG;
        if (chan_hold[ch] > thr_medium)
            return CLS_MEDIUM;
        if (chan_hold[ch] > thr_short)
            return CLS_SHORT;
        return CLS_PRESSED;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: ready changes at the falling edge only. After each accepted
    // item a random stall may follow; the long hold-off wins.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (sink_hold) begin
            grades_if.ready <= 1'b0;
        end else if (sink_stall > 0) begin
            grades_if.ready <= 1'b0;
            sink_stall      <= sink_stall - 1;
        end else begin
            grades_if.ready <= 1'b1;
        end
    end

    // Result checker: compare every accepted item against the oldest expectation.
    always @(posedge i_clk) begin
        t_grade_item head;
        if (i_rst_n && grades_if.valid && grades_if.ready) begin
            sink_stall <= sink_idle_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
            if (expected_grades.size() == 0) begin
                report_mismatch($sformatf("unexpected item: channel %0d class %0d",
                                          grades_if.out_channel, grades_if.press_class));
            end else begin
                head = expected_grades.pop_front();
                if (grades_if.out_channel !== head.channel)
                    report_mismatch($sformatf("out_channel %0d, expected %0d",
                                              grades_if.out_channel, head.channel));
                if (grades_if.press_class !== head.grade)
                    report_mismatch($sformatf("channel %0d press_class %0d, expected %0d",
                                              head.channel, grades_if.press_class,
                                              head.grade));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: one sample per call. Payload changes at the falling edge;
    // valid only drops when a gap is drawn, so back-to-back items keep it high.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [CH_BITS-1:0] ch, input logic down,
                               input logic [ELAPSED_BITS-1:0] el);
        int          gap;
        t_grade_item item;
        @(negedge i_clk);
        // flip idling modes now and then so both busy and quiet stretches occur
        if (idle_toggle_en && $urandom_range(0, 47) == 0)
            src_idle_on = ~src_idle_on;
        if (idle_toggle_en && $urandom_range(0, 47) == 0)
            sink_idle_on = ~sink_idle_on;
        gap = src_idle_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
        if (gap > 0) begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        samples_if.valid       <= 1'b1;
        samples_if.channel     <= ch;
        samples_if.switch_down <= down;
        samples_if.elapsed_ms  <= el;
        @(posedge i_clk);
        while (!samples_if.ready) @(posedge i_clk);
        item.channel = ch;
        item.grade   = debounce_and_grade(ch, down, el);
        expected_grades.push_back(item);
        samples_sent++;
    endtask

    // Drop valid and wait until every expected grade has come back.
    task automatic drain_results;
        @(negedge i_clk);
        samples_if.valid <= 1'b0;
        while (expected_grades.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [CFG_IDX_BITS-1:0] idx,
                                   input logic [THRESH_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_SHORT:  thr_short  = data;
            CFG_MEDIUM: thr_medium = data;
            CFG_LONG:   thr_long   = data;
            default: ;  // out-of-range index: ignored
        endcase
    endtask

    // Only called with the block idle; channel state carries across.
    task automatic program_thresholds(input logic [THRESH_BITS-1:0] s,
                                      input logic [THRESH_BITS-1:0] m,
                                      input logic [THRESH_BITS-1:0] l);
        drain_results();
        write_threshold(CFG_UNUSED, THRESH_BITS'($urandom_range(0, 65535)));
        write_threshold(CFG_SHORT, s);
        write_threshold(CFG_MEDIUM, m);
        write_threshold(CFG_LONG, l);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Well-formed press: hold one channel down long enough to debounce, with
    // occasional samples of other channels woven in, then release it.
    task automatic press_sequence(input logic [CH_BITS-1:0] ch, input int hold_len,
                                  input int el_lo, input int el_hi);
        for (int i = 0; i < hold_len; i++) begin
            if ($urandom_range(0, 5) == 0)
                send_sample(ch ^ CH_BITS'($urandom_range(1, CHANNELS - 1)),
                            1'($urandom_range(0, 1)),
                            ELAPSED_BITS'($urandom_range(0, 1023)));
            send_sample(ch, 1'b1, ELAPSED_BITS'($urandom_range(el_lo, el_hi)));
        end
        repeat ($urandom_range(1, 3))
            send_sample(ch, 1'b0, ELAPSED_BITS'($urandom_range(0, 1023)));
    endtask

    // Random mix: mostly full presses (short, or long enough to saturate the
    // timer), some raw noise, some contact bounce that never debounces.
    task automatic run_random_samples(input int count);
        int stop_at;
        int kind;
        logic [CH_BITS-1:0] ch;
        stop_at = samples_sent + count;
        while (samples_sent < stop_at) begin
            kind = $urandom_range(0, 9);
            ch   = CH_BITS'($urandom_range(0, CHANNELS - 1));
            if (kind < 6) begin
                if ($urandom_range(0, 1))
                    press_sequence(ch, $urandom_range(13, 30), 0, 63);
                else
                    press_sequence(ch, $urandom_range(13, 30), 0, 1023);
            end else if (kind == 6) begin
                press_sequence(ch, $urandom_range(90, 120), 800, 1023);
            end else if (kind < 9) begin
                repeat ($urandom_range(1, 8))
                    send_sample(CH_BITS'($urandom_range(0, CHANNELS - 1)),
                                1'($urandom_range(0, 1)),
                                ELAPSED_BITS'($urandom_range(0, 1023)));
            end else begin
                repeat ($urandom_range(1, DEBOUNCE_SAMPLES - 1))
                    send_sample(ch, 1'b1, ELAPSED_BITS'($urandom_range(0, 1023)));
                send_sample(ch, 1'b0, ELAPSED_BITS'($urandom_range(0, 1023)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Up samples at both channel and elapsed extremes, and a single-sample
    // bounce that must stay released.
    task automatic test_release_extremes;
        send_sample(3'd0, 1'b0, 10'd0);
        send_sample(3'd7, 1'b0, 10'd1023);
        send_sample(3'd3, 1'b1, 10'd1023);
        send_sample(3'd3, 1'b0, 10'd0);
    endtask

    // Walk channel 7 through every grade with the reset thresholds:
    // twelve downs stay released, the thirteenth with zero elapsed is
    // pressed, then six 1023 ms steps climb through short, medium, long; release clears.
    task automatic test_press_grading;
        repeat (DEBOUNCE_SAMPLES - 1) send_sample(3'd7, 1'b1, 10'd1023);
        send_sample(3'd7, 1'b1, 10'd0);
        repeat (6) send_sample(3'd7, 1'b1, 10'd1023);
        send_sample(3'd7, 1'b0, 10'd1023);
    endtask

    task automatic test_random_default;
        run_random_samples(250);
    endtask

    // All thresholds zero: any nonzero hold is long.
    task automatic test_zero_thresholds;
        program_thresholds('0, '0, '0);
        run_random_samples(150);
    endtask

    // All thresholds at maximum: even a saturated timer is only pressed.
    task automatic test_max_thresholds;
        program_thresholds('1, '1, '1);
        run_random_samples(250);
    endtask

    // Small ordered thresholds so short presses spread over all grades.
    task automatic test_ordered_thresholds;
        program_thresholds(16'd100, 16'd400, 16'd1500);
        run_random_samples(150);
    endtask

    // Arbitrary, possibly unordered thresholds.
    task automatic test_random_thresholds;
        repeat (3) begin
            program_thresholds(THRESH_BITS'($urandom_range(0, 8000)),
                               THRESH_BITS'($urandom_range(0, 8000)),
                               THRESH_BITS'($urandom_range(0, 8000)));
            run_random_samples(150);
        end
    endtask

    // Receiver holds off for a long stretch while the sender streams without
    // gaps, so the block fills and drops its input ready.
    task automatic test_backpressure;
        drain_results();
        idle_toggle_en = 1'b0;
        src_idle_on    = 1'b0;
        fork
            begin
                @(posedge i_clk);
                sink_hold = 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                sink_hold = 1'b0;
            end
            begin
                press_sequence(3'd2, 20, 0, 1023);
                press_sequence(3'd5, 20, 0, 1023);
            end
        join
        idle_toggle_en = 1'b1;
        src_idle_on    = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = CFG_SHORT;
        i_cfg_data             = '0;
        samples_if.valid       = 1'b0;
        samples_if.channel     = '0;
        samples_if.switch_down = 1'b0;
        samples_if.elapsed_ms  = '0;
        grades_if.ready        = 1'b0;
        thr_short  = SHORT_RESET;
        thr_medium = MEDIUM_RESET;
        thr_long   = LONG_RESET;
        for (int c = 0; c < CHANNELS; c++) begin
            chan_hist[c] = '1;
            chan_hold[c] = '0;
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_release_extremes();
        test_press_grading();
        test_random_default();
        test_zero_thresholds();
        test_max_thresholds();
        test_ordered_thresholds();
        test_random_thresholds();
        test_backpressure();

        drain_results();
        repeat (4) @(posedge i_clk);  // room for any stray late item

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
